### src/npcs_pkg.sv
// Shared types, constants and helper functions for the nearest palette colour search.
package npcs_pkg;

    localparam int PALETTE_DEPTH     = 256;
    localparam int KEPT_CHANNEL_BITS = 6;

    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 8;
    localparam int DIST_W  = 20;
    localparam int CFG_W   = 9;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
    localparam int BOUND_W = $clog2(PALETTE_DEPTH + 1);
    localparam int ENTRY_W = 3 * CHAN_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DROP_BITS = CHAN_W - KEPT_CHANNEL_BITS;

    // Redmean weights, scaled by 256.
    localparam int RED_BASE    = 512;
    localparam int BLUE_BASE   = 767;
    localparam int GREEN_SHIFT = 10;
    localparam int DIST_SHIFT  = 8;
    localparam int SQ_W        = 2 * CHAN_W;
    localparam int WEIGHT_W    = 10;
    localparam int PROD_W      = WEIGHT_W + SQ_W;
    localparam int SUM_W       = DIST_W + DIST_SHIFT;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [DIST_W-1:0]    dist_t;
    typedef logic [CFG_W-1:0]     cfg_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [BOUND_W-1:0]   bound_t;
    typedef logic [ENTRY_W-1:0]   entry_t;
    typedef logic [QPTR_W-1:0]    qptr_t;
    typedef logic [QCNT_W-1:0]    qcnt_t;
    typedef logic [SQ_W-1:0]      sq_t;
    typedef logic [WEIGHT_W-1:0]  weight_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [OUT_DATA_W-1:0] out_data_t;

    localparam dist_t NO_DISTANCE = '1;

    // Request kinds carried in tuser.
    typedef logic [REQ_W-1:0] req_t;
    localparam req_t REQ_WRITE   = 2'd0;
    localparam req_t REQ_NEAREST = 2'd1;
    localparam req_t REQ_RESHADE = 2'd2;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SEARCH_START   = 2'd0;
    localparam cfg_idx_t CFG_RESERVED_START = 2'd1;
    localparam cfg_idx_t CFG_RESERVED_END   = 2'd2;
    localparam cfg_idx_t CFG_SEARCH_END     = 2'd3;

    localparam cfg_t RST_SEARCH_START   = 9'd1;
    localparam cfg_t RST_RESERVED_START = 9'd198;
    localparam cfg_t RST_RESERVED_END   = 9'd206;
    localparam cfg_t RST_SEARCH_END     = 9'd215;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_kind_t;

    // One queued command: a palette write or a search over two index ranges.
    typedef struct packed {
        cmd_kind_t kind;
        addr_t     addr;
        chan_t     red;
        chan_t     green;
        chan_t     blue;
        bound_t    lo1;
        bound_t    hi1;
        bound_t    lo2;
        bound_t    hi2;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } back_state_t;

    // Keep the top channel bits and set the bit just below them.
    function automatic chan_t crunch(input chan_t c);
        chan_t keep_mask;
        chan_t mid_bit;
        begin
            keep_mask = chan_t'(((1 << KEPT_CHANNEL_BITS) - 1) << DROP_BITS);
            mid_bit   = chan_t'(1 << (DROP_BITS - 1));
            return (c & keep_mask) | mid_bit;
        end
    endfunction

    function automatic bound_t clamp_bound(input cfg_t v);
        begin
            if (int'(v) > PALETTE_DEPTH)
                return bound_t'(PALETTE_DEPTH);
            return bound_t'(v);
        end
    endfunction

    function automatic logic write_in_range(input idx_t idx);
        begin
            return int'(idx) < PALETTE_DEPTH;
        end
    endfunction

    function automatic chan_t abs_diff(input chan_t a, input chan_t b);
        begin
            return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
        end
    endfunction

endpackage

### src/npcs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/npcs_front.sv
// Front end: accepts request words, holds the configuration, crunches queries and queues commands.
module npcs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [npcs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  npcs_pkg::req_t               s_axis_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  npcs_pkg::cfg_idx_t           cfg_index,
    input  npcs_pkg::cfg_t               cfg_data,
    output npcs_pkg::cmd_t               cmd,
    output logic                         cmd_valid,
    input  logic                         cmd_ready
);

    npcs_pkg::cfg_t search_start_reg;
    npcs_pkg::cfg_t reserved_start_reg;
    npcs_pkg::cfg_t reserved_end_reg;
    npcs_pkg::cfg_t search_end_reg;

    npcs_pkg::cmd_t  queue_reg [npcs_pkg::QUEUE_DEPTH];
    npcs_pkg::qptr_t wr_ptr_reg;
    npcs_pkg::qptr_t rd_ptr_reg;
    npcs_pkg::qcnt_t count_reg;

    npcs_pkg::idx_t  entry_index;
    npcs_pkg::chan_t in_red;
    npcs_pkg::chan_t in_green;
    npcs_pkg::chan_t in_blue;
    npcs_pkg::chan_t grey;

    npcs_pkg::cmd_t  new_cmd;
    logic            new_cmd_valid;
    logic            accept;
    logic            push;
    logic            pop;

    assign entry_index = s_axis_tdata[7:0];
    assign in_red      = s_axis_tdata[15:8];
    assign in_green    = s_axis_tdata[23:16];
    assign in_blue     = s_axis_tdata[31:24];
    assign grey        = npcs_pkg::crunch(in_blue);

    assign s_axis_tready = (count_reg != npcs_pkg::qcnt_t'(npcs_pkg::QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        new_cmd       = '0;
        new_cmd_valid = 1'b0;
        unique case (s_axis_tuser)
            npcs_pkg::REQ_WRITE:
            begin
                new_cmd_valid = npcs_pkg::write_in_range(entry_index);
                new_cmd.kind  = npcs_pkg::CMD_WRITE;
                new_cmd.addr  = npcs_pkg::addr_t'(entry_index);
                new_cmd.red   = in_red;
                new_cmd.green = in_green;
                new_cmd.blue  = in_blue;
            end
            npcs_pkg::REQ_NEAREST:
            begin
                new_cmd_valid = 1'b1;
                new_cmd.kind  = npcs_pkg::CMD_SEARCH;
                new_cmd.red   = npcs_pkg::crunch(in_red);
                new_cmd.green = npcs_pkg::crunch(in_green);
                new_cmd.blue  = npcs_pkg::crunch(in_blue);
                new_cmd.lo1   = npcs_pkg::clamp_bound(search_start_reg);
                new_cmd.hi1   = npcs_pkg::clamp_bound(reserved_start_reg);
                new_cmd.lo2   = npcs_pkg::clamp_bound(reserved_end_reg);
                new_cmd.hi2   = npcs_pkg::clamp_bound(search_end_reg);
            end
            npcs_pkg::REQ_RESHADE:
            begin
                // Only the reserved hole is searched; the second range stays empty.
                new_cmd_valid = 1'b1;
                new_cmd.kind  = npcs_pkg::CMD_SEARCH;
                new_cmd.red   = grey;
                new_cmd.green = grey;
                new_cmd.blue  = grey;
                new_cmd.lo1   = npcs_pkg::clamp_bound(reserved_start_reg);
                new_cmd.hi1   = npcs_pkg::clamp_bound(reserved_end_reg);
            end
            default:
            begin
                new_cmd_valid = 1'b0;
            end
        endcase
    end

    assign push      = accept && new_cmd_valid;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_start_reg   <= npcs_pkg::RST_SEARCH_START;
            reserved_start_reg <= npcs_pkg::RST_RESERVED_START;
            reserved_end_reg   <= npcs_pkg::RST_RESERVED_END;
            search_end_reg     <= npcs_pkg::RST_SEARCH_END;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                npcs_pkg::CFG_SEARCH_START:   search_start_reg   <= cfg_data;
                npcs_pkg::CFG_RESERVED_START: reserved_start_reg <= cfg_data;
                npcs_pkg::CFG_RESERVED_END:   reserved_end_reg   <= cfg_data;
                npcs_pkg::CFG_SEARCH_END:     search_end_reg     <= cfg_data;
                default:                      search_start_reg   <= search_start_reg;
            endcase
        end
    end

endmodule

### src/npcs_back.sv
// Back end: palette memory, scan sequencer, pipelined redmean distance and output register.
module npcs_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  npcs_pkg::cmd_t                   cmd,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [npcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    npcs_pkg::back_state_t state_reg, state_next;

    npcs_pkg::bound_t ptr_reg, ptr_next;
    npcs_pkg::bound_t hi_reg, hi_next;
    npcs_pkg::bound_t lo2_reg, lo2_next;
    npcs_pkg::bound_t hi2_reg, hi2_next;
    logic             phase_reg, phase_next;
    npcs_pkg::chan_t  qr_reg, qr_next;
    npcs_pkg::chan_t  qg_reg, qg_next;
    npcs_pkg::chan_t  qb_reg, qb_next;

    npcs_pkg::addr_t  best_idx_reg, best_idx_next;
    npcs_pkg::dist_t  best_dist_reg, best_dist_next;

    logic                  m_valid_reg, m_valid_next;
    npcs_pkg::out_data_t   m_data_reg, m_data_next;

    logic             ram_wr_en;
    logic             ram_rd_en;
    npcs_pkg::addr_t  ram_rd_addr;
    npcs_pkg::entry_t ram_rd_data;

    // Distance pipeline: read, squares, weighted products, floored sum.
    logic             rd_v_reg;
    npcs_pkg::addr_t  rd_idx_reg;
    logic             s1_v_reg;
    npcs_pkg::addr_t  s1_idx_reg;
    npcs_pkg::sq_t    s1_sqr_reg, s1_sqg_reg, s1_sqb_reg;
    npcs_pkg::chan_t  s1_avg_reg;
    logic             s2_v_reg;
    npcs_pkg::addr_t  s2_idx_reg;
    npcs_pkg::prod_t  s2_wr_reg, s2_wb_reg;
    npcs_pkg::sq_t    s2_sqg_reg;
    logic             s3_v_reg;
    npcs_pkg::addr_t  s3_idx_reg;
    npcs_pkg::dist_t  s3_dist_reg;

    npcs_pkg::chan_t  pr, pg, pb;
    npcs_pkg::chan_t  dr, dg, db;
    npcs_pkg::weight_t w_red, w_blue;
    npcs_pkg::sum_t   sum;
    logic             pipe_busy;
    logic             pop;

    npcs_ram #(
        .WIDTH (npcs_pkg::ENTRY_W),
        .DEPTH (npcs_pkg::PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cmd.addr),
        .wr_data ({cmd.red, cmd.green, cmd.blue}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cmd_ready   = (state_reg == npcs_pkg::ST_IDLE);
    assign pop         = cmd_valid && cmd_ready;
    assign ram_wr_en   = pop && (cmd.kind == npcs_pkg::CMD_WRITE);
    assign ram_rd_addr = npcs_pkg::addr_t'(ptr_reg);
    assign pipe_busy   = rd_v_reg || s1_v_reg || s2_v_reg || s3_v_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        hi_next        = hi_reg;
        lo2_next       = lo2_reg;
        hi2_next       = hi2_reg;
        phase_next     = phase_reg;
        qr_next        = qr_reg;
        qg_next        = qg_reg;
        qb_next        = qb_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        ram_rd_en      = 1'b0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        // Strict less-than keeps the first scanned index among equal distances.
        if (s3_v_reg && (s3_dist_reg < best_dist_reg))
        begin
            best_dist_next = s3_dist_reg;
            best_idx_next  = s3_idx_reg;
        end

        unique case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                if (pop && (cmd.kind == npcs_pkg::CMD_SEARCH))
                begin
                    ptr_next       = cmd.lo1;
                    hi_next        = cmd.hi1;
                    lo2_next       = cmd.lo2;
                    hi2_next       = cmd.hi2;
                    phase_next     = 1'b0;
                    qr_next        = cmd.red;
                    qg_next        = cmd.green;
                    qb_next        = cmd.blue;
                    best_idx_next  = '0;
                    best_dist_next = npcs_pkg::NO_DISTANCE;
                    state_next     = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN:
            begin
                if (ptr_reg < hi_reg)
                begin
                    ram_rd_en = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    ptr_next   = lo2_reg;
                    hi_next    = hi2_reg;
                end
                else
                begin
                    state_next = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = npcs_pkg::ST_DONE;
                end
            end
            npcs_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = npcs_pkg::out_data_t'({best_dist_reg,
                                                          npcs_pkg::idx_t'(best_idx_reg)});
                    state_next   = npcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign pr     = ram_rd_data[23:16];
    assign pg     = ram_rd_data[15:8];
    assign pb     = ram_rd_data[7:0];
    assign dr     = npcs_pkg::abs_diff(pr, qr_reg);
    assign dg     = npcs_pkg::abs_diff(pg, qg_reg);
    assign db     = npcs_pkg::abs_diff(pb, qb_reg);
    assign w_red  = npcs_pkg::weight_t'(npcs_pkg::RED_BASE) + npcs_pkg::weight_t'(s1_avg_reg);
    assign w_blue = npcs_pkg::weight_t'(npcs_pkg::BLUE_BASE) - npcs_pkg::weight_t'(s1_avg_reg);
    assign sum    = npcs_pkg::sum_t'(s2_wr_reg) + npcs_pkg::sum_t'(s2_wb_reg)
                  + (npcs_pkg::sum_t'(s2_sqg_reg) << npcs_pkg::GREEN_SHIFT);

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        hi_reg        <= hi_next;
        lo2_reg       <= lo2_next;
        hi2_reg       <= hi2_next;
        qr_reg        <= qr_next;
        qg_reg        <= qg_next;
        qb_reg        <= qb_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        m_data_reg    <= m_data_next;

        rd_idx_reg    <= ram_rd_addr;
        s1_idx_reg    <= rd_idx_reg;
        s1_sqr_reg    <= npcs_pkg::sq_t'(dr) * npcs_pkg::sq_t'(dr);
        s1_sqg_reg    <= npcs_pkg::sq_t'(dg) * npcs_pkg::sq_t'(dg);
        s1_sqb_reg    <= npcs_pkg::sq_t'(db) * npcs_pkg::sq_t'(db);
        s1_avg_reg    <= npcs_pkg::chan_t'(({1'b0, pr} + {1'b0, qr_reg}) >> 1);
        s2_idx_reg    <= s1_idx_reg;
        s2_wr_reg     <= npcs_pkg::prod_t'(w_red) * npcs_pkg::prod_t'(s1_sqr_reg);
        s2_wb_reg     <= npcs_pkg::prod_t'(w_blue) * npcs_pkg::prod_t'(s1_sqb_reg);
        s2_sqg_reg    <= s1_sqg_reg;
        s3_idx_reg    <= s2_idx_reg;
        s3_dist_reg   <= npcs_pkg::dist_t'(sum >> npcs_pkg::DIST_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= npcs_pkg::ST_IDLE;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            rd_v_reg    <= ram_rd_en;
            s1_v_reg    <= rd_v_reg;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### src/nearest_palette_colour_search.sv
// Top level of the nearest palette colour search: front end, command queue and scan engine.
//
// Input words arrive on the s_axis channel. tuser carries the request kind (write entry,
// nearest colour, reshade to a grey taken from the blue channel). A write loads one 24-bit palette entry and returns
// nothing; a nearest or reshade request returns one word on m_axis with the winning index
// and its floored redmean distance. Other request kinds are dropped.
// The configuration channel sets the search bounds and the reserved hole; write it only while
// no request is pending.
// A search reads the palette memory one entry per cycle through a single read port, for
// each of the N entries in its ranges (206 with the reset bounds). A write goes straight
// into the memory while the back end stays idle.
// The front end queues up to two commands, so it keeps accepting words while a search runs
// and while a result waits on a stalled receiver; when the queue is full tready drops.
// Reset clears the queue, the pipeline and the output register and restores the default
// bounds; the palette contents are undefined until written.
module nearest_palette_colour_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index [7:0], in_red [15:8], in_green [23:16], in_blue [31:24]
    input  logic [npcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [npcs_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // nearest_index [7:0], nearest_distance [27:8], zero [31:28]
    output logic [npcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [npcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [npcs_pkg::CFG_W-1:0]        cfg_data
);

    npcs_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_ready;

    npcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready)
    );

    npcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### src/npcs_checker.sv
// Port-level checks for the nearest palette colour search, bound to the top level.
module npcs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [npcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // A result word that is not taken stays up.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // An empty search reports index zero together with the all-ones distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[27:8] == npcs_pkg::NO_DISTANCE)
            |-> (m_axis_tdata[7:0] == '0))
        else $error("empty search reported a nonzero index");

    // The padding above the distance field is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:28] == '0))
        else $error("result padding bits are not zero");

endmodule

bind nearest_palette_colour_search npcs_checker u_npcs_checker (.*);
